>>> rtl/bsco_pkg.sv
package bsco_pkg;

  localparam int CW   = 32;
  localparam int FB   = 16;
  localparam int SZW  = 31;
  localparam int PW   = 2 * SZW;
  localparam int HW   = PW - FB;
  localparam int HHW  = SZW - 1;
  localparam int WS   = HW + 4;
  localparam int HALF = (HW + 1) / 2;
  localparam int SQW  = 4 * HALF;
  localparam int SUMW = SQW + 2;
  localparam int NSQ  = 5;
  localparam int LAT  = 7;

  typedef enum logic [2:0] {
    REG_SPHERE_R  = 3'd0,
    REG_HALF_X    = 3'd1,
    REG_HALF_Y    = 3'd2,
    REG_HALF_Z    = 3'd3,
    REG_CAPSULE_R = 3'd4,
    REG_CAP_H     = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_SLAB   = 2'd1,
    HIT_SPHERE = 2'd2
  } hit_e;

  typedef struct packed {
    logic [SZW-1:0] sph_rad;
    logic [SZW-1:0] half_x;
    logic [SZW-1:0] half_y;
    logic [SZW-1:0] half_z;
    logic [SZW-1:0] capsule_r;
    logic [SZW-1:0] cap_h;
  } cfg_t;

endpackage

>>> rtl/bsco_cfg_regs.sv
module bsco_cfg_regs
  import bsco_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [SZW-1:0] cfg_wdata_i,
  output cfg_t           cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SPHERE_R:  cfg_d.sph_rad   = cfg_wdata_i;
        REG_HALF_X:    cfg_d.half_x    = cfg_wdata_i;
        REG_HALF_Y:    cfg_d.half_y    = cfg_wdata_i;
        REG_HALF_Z:    cfg_d.half_z    = cfg_wdata_i;
        REG_CAPSULE_R: cfg_d.capsule_r = cfg_wdata_i;
        REG_CAP_H:     cfg_d.cap_h     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sph_rad   <= SZW'(65536);
      cfg_q.half_x    <= SZW'(32768);
      cfg_q.half_y    <= SZW'(32768);
      cfg_q.half_z    <= SZW'(32768);
      cfg_q.capsule_r <= SZW'(65536);
      cfg_q.cap_h     <= SZW'(131072);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/box_sphere_capsule_overlap_core.sv
// Box against sphere/capsule overlap test, Q16.16. One beat per cycle is
// accepted (busy_o stays low) and its hit_code_o comes out with valid_o,
// one result per beat in order, after seven register stages (scale
// multipliers, bounds, slab compares, axis gaps, split squaring in two
// stages, sum and compare). The receiver cannot stall, so results must be
// taken on the strobe. The user must write configuration through cfg_we_i/
// cfg_idx_i/cfg_wdata_i only while no beat is in flight; not enforced here.
module box_sphere_capsule_overlap_core
  import bsco_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [SZW-1:0]        cfg_wdata_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  func_i,
  input  logic signed [CW-1:0]  box_center_x_i,
  input  logic signed [CW-1:0]  box_center_y_i,
  input  logic signed [CW-1:0]  box_center_z_i,
  input  logic [SZW-1:0]        box_size_x_i,
  input  logic [SZW-1:0]        box_size_y_i,
  input  logic [SZW-1:0]        box_size_z_i,
  input  logic signed [CW-1:0]  shape_center_x_i,
  input  logic signed [CW-1:0]  shape_center_y_i,
  input  logic signed [CW-1:0]  shape_center_z_i,
  input  logic [SZW-1:0]        shape_size_i,
  output logic                  valid_o,
  output logic [1:0]            hit_code_o
);

  cfg_t cfg;

  bsco_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i && !busy_o;

  logic [LAT-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LAT-2:0], accept};
    end
  end

  // stage 1: scaled extents
  logic [PW-1:0] px, py, pz, pr;
  assign px = PW'(box_size_x_i) * PW'(cfg.half_x);
  assign py = PW'(box_size_y_i) * PW'(cfg.half_y);
  assign pz = PW'(box_size_z_i) * PW'(cfg.half_z);
  assign pr = PW'(shape_size_i) * PW'(func_i ? cfg.capsule_r : cfg.sph_rad);

  logic [HW-1:0]         h1_q [3];
  logic [HW-1:0]         r1_q;
  logic [HHW-1:0]        hh1_q;
  logic signed [CW-1:0]  c1_q [3];
  logic signed [CW-1:0]  s1_q [3];
  logic                  f1_q;

  always_ff @(posedge clk_i) begin
    h1_q[0] <= px[PW-1:FB];
    h1_q[1] <= py[PW-1:FB];
    h1_q[2] <= pz[PW-1:FB];
    r1_q    <= pr[PW-1:FB];
    hh1_q   <= cfg.cap_h[SZW-1:1];
    c1_q[0] <= box_center_x_i;
    c1_q[1] <= box_center_y_i;
    c1_q[2] <= box_center_z_i;
    s1_q[0] <= shape_center_x_i;
    s1_q[1] <= shape_center_y_i;
    s1_q[2] <= shape_center_z_i;
    f1_q    <= func_i;
  end

  // stage 2: bounds and center offsets
  logic signed [WS-1:0] h1s [3];
  logic signed [WS-1:0] c1s [3];
  logic signed [WS-1:0] s1s [3];
  logic signed [WS-1:0] r1s, hh1s, yd1, yu1;
  logic signed [WS-1:0] e1 [4];
  logic signed [WS-1:0] cc1 [4];
  logic signed [WS-1:0] d1 [4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h1s[i] = $signed({{(WS-HW){1'b0}}, h1_q[i]});
      c1s[i] = WS'(c1_q[i]);
      s1s[i] = WS'(s1_q[i]);
    end
    r1s  = $signed({{(WS-HW){1'b0}}, r1_q});
    hh1s = $signed({{(WS-HHW){1'b0}}, hh1_q});
    yd1  = s1s[1] - hh1s;
    yu1  = s1s[1] + hh1s;
    e1[0] = s1s[0];
    e1[1] = f1_q ? yd1 : s1s[1];
    e1[2] = yu1;
    e1[3] = s1s[2];
    cc1[0] = c1s[0];
    cc1[1] = c1s[1];
    cc1[2] = c1s[1];
    cc1[3] = c1s[2];
    for (int k = 0; k < 4; k++) begin
      d1[k] = e1[k] - cc1[k];
    end
  end

  logic signed [WS-1:0] lo2_q [3];
  logic signed [WS-1:0] hi2_q [3];
  logic signed [WS-1:0] s2_q [3];
  logic signed [WS-1:0] yd2_q, yu2_q, r2_q;
  logic signed [WS-1:0] d2_q [4];
  logic signed [WS-1:0] h2_q [4];
  logic                 f2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      lo2_q[i] <= c1s[i] - h1s[i];
      hi2_q[i] <= c1s[i] + h1s[i];
      s2_q[i]  <= s1s[i];
    end
    for (int k = 0; k < 4; k++) begin
      d2_q[k] <= d1[k];
    end
    h2_q[0] <= h1s[0];
    h2_q[1] <= h1s[1];
    h2_q[2] <= h1s[1];
    h2_q[3] <= h1s[2];
    yd2_q <= yd1;
    yu2_q <= yu1;
    r2_q  <= r1s;
    f2_q  <= f1_q;
  end

  // stage 3: slab tests and axis gaps
  logic yok, xin, zin, xwide, zwide, slab2;
  logic signed [WS-1:0] t2 [4];

  always_comb begin
    if (f2_q) begin
      yok = (yd2_q >= lo2_q[1] && yd2_q <= hi2_q[1]) ||
            (yu2_q >= lo2_q[1] && yu2_q <= hi2_q[1]);
    end else begin
      yok = s2_q[1] > lo2_q[1] && s2_q[1] < hi2_q[1];
    end
    xin   = s2_q[0] > lo2_q[0] && s2_q[0] < hi2_q[0];
    zin   = s2_q[2] > lo2_q[2] && s2_q[2] < hi2_q[2];
    xwide = s2_q[0] > lo2_q[0] - r2_q && s2_q[0] < hi2_q[0] + r2_q;
    zwide = s2_q[2] > lo2_q[2] - r2_q && s2_q[2] < hi2_q[2] + r2_q;
    slab2 = yok && ((xwide && zin) || (xin && zwide));
    for (int k = 0; k < 4; k++) begin
      t2[k] = h2_q[k] - (d2_q[k] < 0 ? -d2_q[k] : d2_q[k]);
    end
  end

  logic                 slab3_q, f3_q;
  logic signed [WS-1:0] t3_q [4];
  logic signed [WS-1:0] r3_q;

  always_ff @(posedge clk_i) begin
    slab3_q <= slab2;
    f3_q    <= f2_q;
    r3_q    <= r2_q;
    for (int k = 0; k < 4; k++) begin
      t3_q[k] <= t2[k];
    end
  end

  // stage 4: separation flags and gap magnitudes
  logic [3:0]           sep3;
  logic [HW-1:0]        m3 [NSQ];
  logic signed [WS-1:0] nt3 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nt3[k]  = -t3_q[k];
      sep3[k] = t3_q[k] <= -r3_q;
      m3[k]   = (t3_q[k] < 0) ? nt3[k][HW-1:0] : '0;
    end
    m3[4] = r3_q[HW-1:0];
  end

  logic          slab4_q, f4_q;
  logic [3:0]    sep4_q;
  logic [HW-1:0] m4_q [NSQ];

  always_ff @(posedge clk_i) begin
    slab4_q <= slab3_q;
    f4_q    <= f3_q;
    sep4_q  <= sep3;
    for (int k = 0; k < NSQ; k++) begin
      m4_q[k] <= m3[k];
    end
  end

  // stage 5: partial products of the squares
  logic [2*HALF-1:0] p00_5_q [NSQ];
  logic [2*HALF-1:0] p01_5_q [NSQ];
  logic [2*HALF-1:0] p11_5_q [NSQ];
  logic              slab5_q, f5_q;
  logic [3:0]        sep5_q;
  logic [2*HALF-1:0] mext [NSQ];

  always_comb begin
    for (int k = 0; k < NSQ; k++) begin
      mext[k] = (2*HALF)'(m4_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    slab5_q <= slab4_q;
    f5_q    <= f4_q;
    sep5_q  <= sep4_q;
    for (int k = 0; k < NSQ; k++) begin
      p00_5_q[k] <= (2*HALF)'(mext[k][HALF-1:0]) * (2*HALF)'(mext[k][HALF-1:0]);
      p01_5_q[k] <= (2*HALF)'(mext[k][HALF-1:0]) * (2*HALF)'(mext[k][2*HALF-1:HALF]);
      p11_5_q[k] <= (2*HALF)'(mext[k][2*HALF-1:HALF])
                  * (2*HALF)'(mext[k][2*HALF-1:HALF]);
    end
  end

  // stage 6: assemble squares
  logic [SQW-1:0] sq6_q [NSQ];
  logic           slab6_q, f6_q;
  logic [3:0]     sep6_q;

  always_ff @(posedge clk_i) begin
    slab6_q <= slab5_q;
    f6_q    <= f5_q;
    sep6_q  <= sep5_q;
    for (int k = 0; k < NSQ; k++) begin
      sq6_q[k] <= (SQW'(p11_5_q[k]) << (2*HALF)) + (SQW'(p01_5_q[k]) << (HALF+1))
                + SQW'(p00_5_q[k]);
    end
  end

  // stage 7: distance sums and final code
  logic [SUMW-1:0] sum_a, sum_b;
  logic            hit_a, hit_b;
  logic [1:0]      code7;

  always_comb begin
    sum_a = SUMW'(sq6_q[0]) + SUMW'(sq6_q[1]) + SUMW'(sq6_q[3]);
    sum_b = SUMW'(sq6_q[0]) + SUMW'(sq6_q[2]) + SUMW'(sq6_q[3]);
    hit_a = !(sep6_q[0] || sep6_q[1] || sep6_q[3]) && sum_a <= SUMW'(sq6_q[4]);
    hit_b = f6_q && !(sep6_q[0] || sep6_q[2] || sep6_q[3]) && sum_b <= SUMW'(sq6_q[4]);
    if (slab6_q) begin
      code7 = HIT_SLAB;
    end else if (hit_a || hit_b) begin
      code7 = HIT_SPHERE;
    end else begin
      code7 = HIT_NONE;
    end
  end

  logic [1:0] code_q;

  always_ff @(posedge clk_i) begin
    code_q <= code7;
  end

  assign valid_o    = v_q[LAT-1];
  assign hit_code_o = code_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LAT) valid_o) else $error("beat lost in pipeline");

  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT)) else $error("result without beat");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hit_code_o == HIT_NONE || hit_code_o == HIT_SLAB ||
                 hit_code_o == HIT_SPHERE)) else $error("bad hit code");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  import bsco_pkg::*;

  typedef struct {
    logic            func;
    logic [CW-1:0]   bc [3];
    logic [SZW-1:0]  bs [3];
    logic [CW-1:0]   sc [3];
    logic [SZW-1:0]  ss;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = 3'd0;
  logic [SZW-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic func = 1'b0;
  logic signed [CW-1:0] bcx = '0, bcy = '0, bcz = '0, scx = '0, scy = '0, scz = '0;
  logic [SZW-1:0] bsx = '0, bsy = '0, bsz = '0, ssz = '0;
  logic valid;
  logic [1:0] hit_code;

  logic [SZW-1:0] scale_q [6];
  logic [1:0] hit_q [$];
  int errors = 0;
  int cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  box_sphere_capsule_overlap_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .start_i(start), .busy_o(busy), .func_i(func),
    .box_center_x_i(bcx), .box_center_y_i(bcy), .box_center_z_i(bcz),
    .box_size_x_i(bsx), .box_size_y_i(bsy), .box_size_z_i(bsz),
    .shape_center_x_i(scx), .shape_center_y_i(scy), .shape_center_z_i(scz),
    .shape_size_i(ssz), .valid_o(valid), .hit_code_o(hit_code)
  );

  function automatic longint scaled_half(logic [SZW-1:0] sz, logic [SZW-1:0] sc);
    logic [63:0] p;
    p = {33'b0, sz} * {33'b0, sc};
    return longint'(p >> FB);
  endfunction

  function automatic logic [129:0] sq(longint a);
    logic [129:0] w;
    w = {66'b0, a[63:0]};
    return w * w;
  endfunction

  function automatic bit dist_hit(longint c [3], longint h [3], longint s [3], longint r);
    logic [129:0] acc;
    longint d, t;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      d = s[i] - c[i];
      t = h[i] - (d < 0 ? -d : d);
      if (t <= -r) return 1'b0;
      if (t < 0) acc = acc + sq(-t);
    end
    return acc <= sq(r);
  endfunction

  function automatic logic [1:0] overlap_code(pair_t p);
    longint c [3], h [3], s [3], lo [3], hi [3], e [3];
    longint r, hh, yd, yu;
    bit yok, xin, zin, xw, zw;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed(p.bc[i]));
      s[i] = longint'($signed(p.sc[i]));
      h[i] = scaled_half(p.bs[i], scale_q[REG_HALF_X + i]);
      lo[i] = c[i] - h[i];
      hi[i] = c[i] + h[i];
    end
    r = scaled_half(p.ss, p.func ? scale_q[REG_CAPSULE_R] : scale_q[REG_SPHERE_R]);
    hh = longint'(scale_q[REG_CAP_H] >> 1);
    yd = s[1] - hh;
    yu = s[1] + hh;
    if (p.func) yok = (yd >= lo[1] && yd <= hi[1]) || (yu >= lo[1] && yu <= hi[1]);
    else yok = s[1] > lo[1] && s[1] < hi[1];
    xin = s[0] > lo[0] && s[0] < hi[0];
    zin = s[2] > lo[2] && s[2] < hi[2];
    xw = s[0] > lo[0] - r && s[0] < hi[0] + r;
    zw = s[2] > lo[2] - r && s[2] < hi[2] + r;
    if (yok && ((xw && zin) || (xin && zw))) return HIT_SLAB;
    if (p.func) begin
      e = s;
      e[1] = yd;
      if (dist_hit(c, h, e, r)) return HIT_SPHERE;
      e[1] = yu;
      if (dist_hit(c, h, e, r)) return HIT_SPHERE;
      return HIT_NONE;
    end
    return dist_hit(c, h, s, r) ? HIT_SPHERE : HIT_NONE;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (valid) begin
        if (hit_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat: hit_code %0d", hit_code);
        end else begin
          if (hit_code !== hit_q[0]) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("hit_code mismatch: expected %0d actual %0d", hit_q[0], hit_code);
          end
          void'(hit_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_pair(pair_t p);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = p.func;
    bcx = p.bc[0]; bcy = p.bc[1]; bcz = p.bc[2];
    bsx = p.bs[0]; bsy = p.bs[1]; bsz = p.bs[2];
    scx = p.sc[0]; scy = p.sc[1]; scz = p.sc[2];
    ssz = p.ss;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    hit_q.push_back(overlap_code(p));
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (hit_q.size() != 0) @(negedge clk);
    repeat (LAT + 2) @(negedge clk);
  endtask

  task automatic write_scales(logic [SZW-1:0] v [6]);
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we = 1'b1;
      cfg_idx = 3'(i);
      cfg_wdata = v[i];
      scale_q[i] = v[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p.func = 1'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) begin
      p.bc[i] = $urandom;
      if (mode < 7) begin
        p.bs[i] = SZW'($urandom_range(0, 32'h0008_0000));
        p.sc[i] = p.bc[i] + $signed($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000;
      end else begin
        p.bs[i] = SZW'($urandom);
        p.sc[i] = $urandom;
      end
    end
    p.ss = (mode < 8) ? SZW'($urandom_range(0, 32'h0004_0000)) : SZW'($urandom);
    return p;
  endfunction

  function automatic pair_t mk(logic f, logic [CW-1:0] b, logic [SZW-1:0] bs,
                               logic [CW-1:0] s, logic [SZW-1:0] ss);
    pair_t p;
    p.func = f;
    for (int i = 0; i < 3; i++) begin
      p.bc[i] = b; p.bs[i] = bs; p.sc[i] = s;
    end
    p.ss = ss;
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    for (int f = 0; f < 2; f++) begin
      send_pair(mk(1'(f), '0, '0, '0, '0));
      send_pair(mk(1'(f), 32'h7fff_ffff, '1, 32'h8000_0000, '1));
      send_pair(mk(1'(f), 32'h8000_0000, '1, 32'h7fff_ffff, '0));
      send_pair(mk(1'(f), '0, 31'h0002_0000, 32'h0000_8000, '0));
      send_pair(mk(1'(f), '0, 31'h0002_0000, 32'h0001_8000, 31'h0001_0000));
      send_pair(mk(1'(f), '0, 31'h0002_0000, 32'h0003_0000, '0));
      p = mk(1'(f), '0, 31'h0002_0000, '0, 31'h0000_8000);
      p.sc[0] = 32'h0001_4000;
      send_pair(p);
      p = mk(1'(f), '0, 31'h0002_0000, 32'h0001_2000, 31'h0000_8000);
      send_pair(p);
      p.sc[1] = 32'h0002_0000;
      send_pair(p);
      p = mk(1'(f), 32'hffff_0000, '1, 32'h0001_0000, '1);
      p.bc[1] = 32'h5555_aaaa; p.sc[2] = 32'haaaa_5555;
      send_pair(p);
    end
  endtask

  task automatic test_random(logic [SZW-1:0] v [6], int n);
    write_scales(v);
    repeat (n) send_pair(rand_pair());
  endtask

  initial begin
    logic [SZW-1:0] v [6];
    scale_q = '{31'd65536, 31'd32768, 31'd32768, 31'd32768, 31'd65536, 31'd131072};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(scale_q, 300);
    v = '{'0, '0, '0, '0, '0, '0};
    test_random(v, 150);
    v = '{'1, '1, '1, '1, '1, '1};
    test_random(v, 150);
    v = '{31'd65536, 31'd65536, 31'd16384, 31'd98304, 31'd131072, 31'd1};
    test_random(v, 300);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 6; i++) v[i] = SZW'($urandom_range(0, 32'h0003_0000));
      test_random(v, 170);
    end
    drain();
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bsco_pkg.sv
rtl/bsco_cfg_regs.sv
rtl/box_sphere_capsule_overlap_core.sv
tb/sv/tb_top.sv
